// ===== rtl/core/q8b_pkg.sv =====
// Shared constants, codes and stage types for the q8_0 block dot product core.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
package q8b_pkg;

  // Block geometry.
  localparam int BLOCK_SIZE      = 32;
  localparam int LANES           = 4;
  localparam int ITEMS_PER_BLOCK = ((BLOCK_SIZE / LANES) > 0) ? (BLOCK_SIZE / LANES) : 1;
  localparam int ELEMS_PER_BLOCK = ITEMS_PER_BLOCK * LANES;
  localparam int CNT_W           = (ITEMS_PER_BLOCK > 1) ? $clog2(ITEMS_PER_BLOCK) : 1;

  // Field widths.
  localparam int ACT_W   = 24;
  localparam int QUANT_W = 8;
  localparam int SCALE_W = 16;
  localparam int ACC_W   = 64;

  // Datapath widths: one product reaches 2^30 in magnitude, a block sum
  // reaches ELEMS_PER_BLOCK times that.
  localparam int PROD_W  = ACT_W + QUANT_W;
  localparam int SUM_W   = $clog2(ELEMS_PER_BLOCK) + PROD_W;
  localparam int MANT_W  = 11;
  localparam int SH_W    = 5;
  localparam int MAG_W   = SUM_W + MANT_W;
  localparam int SHIFT_W = MAG_W + 29;

  // fp16 exponent that marks infinity and NaN.
  localparam logic [4:0] EXP_SPECIAL = 5'h1F;

  // Accumulator extremes.
  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // What a closed block does to the row accumulator.
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_FORCE = 2'd2;

  // A closed block on its way to the scaling stages.
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [SUM_W-1:0]   sum;
    logic [SCALE_W-1:0] scale;
  } close_t;

  // A scaled block term on its way to the accumulator.
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [OP_W-1:0]  op;
    logic             sat;
    logic [ACC_W-1:0] value;
  } term_t;

endpackage

// ===== rtl/core/q8b_lane.sv =====
// One multiply lane: registers the product of an activation and an int8 quant.
// Depends on q8b_pkg for widths.
module q8b_lane (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [q8b_pkg::ACT_W-1:0]     act,
  input  logic signed [q8b_pkg::QUANT_W-1:0]   quant,
  output logic signed [q8b_pkg::PROD_W-1:0]    prod
);

  // The product fits the register exactly, so no rounding or clipping.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= q8b_pkg::PROD_W'(act) * q8b_pkg::PROD_W'(quant);
    end
  end

endmodule

// ===== rtl/core/q8b_merge.sv =====
// Merge stage: adds the lane products into the open block sum and closes the
// block when it is full or the row ends. Depends on q8b_pkg.
module q8b_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic                                in_last,
  input  logic [q8b_pkg::SCALE_W-1:0]         in_scale,
  input  logic signed [q8b_pkg::PROD_W-1:0]   prod [q8b_pkg::LANES],
  output q8b_pkg::close_t                     close_out
);

  logic signed [q8b_pkg::SUM_W-1:0] block_sum;
  logic [q8b_pkg::CNT_W-1:0]        item_in_block;
  logic signed [q8b_pkg::SUM_W-1:0] lane_sum;
  logic signed [q8b_pkg::SUM_W-1:0] block_sum_next;
  logic                             closing;

  // Sum of the lanes of this item, then the running block sum.
  always_comb begin
    lane_sum = '0;
    for (int i = 0; i < q8b_pkg::LANES; i++) begin
      lane_sum = lane_sum + q8b_pkg::SUM_W'(prod[i]);
    end
    block_sum_next = block_sum + lane_sum;
    closing = in_valid &&
              (in_last || (item_in_block == q8b_pkg::CNT_W'(q8b_pkg::ITEMS_PER_BLOCK - 1)));
  end

  // Block state; a closing item starts a fresh block.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_sum     <= '0;
      item_in_block <= '0;
    end else if (en && in_valid) begin
      if (closing) begin
        block_sum     <= '0;
        item_in_block <= '0;
      end else begin
        block_sum     <= block_sum_next;
        item_in_block <= item_in_block + q8b_pkg::CNT_W'(1);
      end
    end
  end

  // Closed block handed to the scaling stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      close_out.valid <= 1'b0;
    end else if (en) begin
      close_out.valid <= closing;
      close_out.last  <= in_last;
      close_out.sum   <= block_sum_next;
      close_out.scale <= in_scale;
    end
  end

endmodule

// ===== rtl/core/q8b_scale.sv =====
// Scaling stages: decodes the fp16 block scale into mantissa and shift,
// multiplies the block sum, then shifts and clips the term to 64 bits.
// Depends on q8b_pkg.
module q8b_scale (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  q8b_pkg::close_t close_in,
  output q8b_pkg::term_t  term_out
);

  // First stage: decode and multiply.
  logic                             sgn;
  logic [4:0]                       ex;
  logic [9:0]                       fr;
  logic [q8b_pkg::MANT_W-1:0]       mant;
  logic [q8b_pkg::SH_W-1:0]         sh;
  logic signed [q8b_pkg::SUM_W-1:0] sum_s;
  logic [q8b_pkg::SUM_W-1:0]        sum_abs;

  logic                             m_valid;
  logic                             m_last;
  logic                             m_special;
  logic                             m_fr_zero;
  logic                             m_sum_nz;
  logic                             m_neg;
  logic [q8b_pkg::SH_W-1:0]         m_sh;
  logic [q8b_pkg::MAG_W-1:0]        m_mag;

  always_comb begin
    sgn     = close_in.scale[15];
    ex      = close_in.scale[14:10];
    fr      = close_in.scale[9:0];
    sum_s   = $signed(close_in.sum);
    // A subnormal scale has no hidden bit and no shift.
    mant    = (ex == 5'd0) ? {1'b0, fr} : {1'b1, fr};
    sh      = (ex == 5'd0) ? '0 : (ex - 5'd1);
    sum_abs = sum_s[q8b_pkg::SUM_W-1] ? q8b_pkg::SUM_W'(-sum_s) : q8b_pkg::SUM_W'(sum_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= close_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_last    <= close_in.last;
      m_special <= (ex == q8b_pkg::EXP_SPECIAL);
      m_fr_zero <= (fr == 10'd0);
      m_sum_nz  <= (close_in.sum != '0);
      m_neg     <= sum_s[q8b_pkg::SUM_W-1] ^ sgn;
      m_sh      <= sh;
      m_mag     <= q8b_pkg::MAG_W'(sum_abs) * q8b_pkg::MAG_W'(mant);
    end
  end

  // Second stage: shift into 2^-24 units and clip to the 64-bit range.
  logic [q8b_pkg::SHIFT_W-1:0] shifted;
  logic                        at_least_top;
  logic                        exactly_top;
  q8b_pkg::term_t              term_next;

  always_comb begin
    shifted      = q8b_pkg::SHIFT_W'(m_mag) << m_sh;
    at_least_top = (shifted[q8b_pkg::SHIFT_W-1:q8b_pkg::ACC_W-1] != '0);
    exactly_top  = (shifted[q8b_pkg::SHIFT_W-1:q8b_pkg::ACC_W] == '0) &&
                   shifted[q8b_pkg::ACC_W-1] &&
                   (shifted[q8b_pkg::ACC_W-2:0] == '0);

    term_next.valid = m_valid;
    term_next.last  = m_last;
    term_next.op    = q8b_pkg::OP_ADD;
    term_next.sat   = 1'b0;
    term_next.value = shifted[q8b_pkg::ACC_W-1:0];

    if (m_special) begin
      // Infinity with a nonzero sum forces the extreme; NaN or a zero sum
      // leaves the accumulator alone. Either way the row is flagged.
      term_next.sat = 1'b1;
      if (m_fr_zero && m_sum_nz) begin
        term_next.op    = q8b_pkg::OP_FORCE;
        term_next.value = m_neg ? q8b_pkg::ACC_MIN : q8b_pkg::ACC_MAX;
      end else begin
        term_next.op    = q8b_pkg::OP_NONE;
      end
    end else if (m_neg) begin
      // A negative term may reach exactly -2^63 without clipping.
      if (at_least_top && !exactly_top) begin
        term_next.sat   = 1'b1;
        term_next.value = q8b_pkg::ACC_MIN;
      end else begin
        term_next.value = -shifted[q8b_pkg::ACC_W-1:0];
      end
    end else if (at_least_top) begin
      term_next.sat   = 1'b1;
      term_next.value = q8b_pkg::ACC_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term_out.valid <= 1'b0;
    end else if (en) begin
      term_out.valid <= term_next.valid;
      term_out.last  <= term_next.last;
      term_out.op    <= term_next.op;
      term_out.sat   <= term_next.sat;
      term_out.value <= term_next.value;
    end
  end

endmodule

// ===== rtl/core/q8b_accum.sv =====
// Row accumulator with saturating add, and the output register that holds
// one finished row until it is taken. Depends on q8b_pkg.
module q8b_accum (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  q8b_pkg::term_t              term_in,
  output logic                        out_valid,
  output logic [q8b_pkg::ACC_W-1:0]   out_value,
  output logic                        out_sat
);

  logic [q8b_pkg::ACC_W-1:0] row_accumulator;
  logic                      row_saturated;
  logic [q8b_pkg::ACC_W:0]   wide_sum;
  logic                      ovf;
  logic [q8b_pkg::ACC_W-1:0] acc_next;
  logic                      sat_next;

  // Saturating add: a 65-bit sum overflowed when its top two bits differ.
  always_comb begin
    wide_sum = {row_accumulator[q8b_pkg::ACC_W-1], row_accumulator} +
               {term_in.value[q8b_pkg::ACC_W-1], term_in.value};
    ovf      = wide_sum[q8b_pkg::ACC_W] != wide_sum[q8b_pkg::ACC_W-1];
    acc_next = row_accumulator;
    sat_next = row_saturated | term_in.sat;
    unique case (term_in.op)
      q8b_pkg::OP_ADD: begin
        if (ovf) begin
          acc_next = wide_sum[q8b_pkg::ACC_W] ? q8b_pkg::ACC_MIN : q8b_pkg::ACC_MAX;
          sat_next = 1'b1;
        end else begin
          acc_next = wide_sum[q8b_pkg::ACC_W-1:0];
        end
      end
      q8b_pkg::OP_FORCE: begin
        acc_next = term_in.value;
      end
      default: begin
        acc_next = row_accumulator;
      end
    endcase
  end

  // Row state; a row end hands the total over and clears the row.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_accumulator <= '0;
      row_saturated   <= 1'b0;
    end else if (en && term_in.valid) begin
      if (term_in.last) begin
        row_accumulator <= '0;
        row_saturated   <= 1'b0;
      end else begin
        row_accumulator <= acc_next;
        row_saturated   <= sat_next;
      end
    end
  end

  // Output register. The pipeline only moves when this register is free or
  // being read, so a held result is never overwritten.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= term_in.valid && term_in.last;
    end
  end

  always_ff @(posedge clk) begin
    if (en && term_in.valid && term_in.last) begin
      out_value <= acc_next;
      out_sat   <= sat_next;
    end
  end

endmodule

// ===== rtl/core/q8_0_block_dot_product_core.sv =====
// Top level of the q8_0 block dot product core: four multiply lanes, the
// block merge stage, the fp16 scaling stages and the row accumulator.
// Depends on q8b_pkg, q8b_lane, q8b_merge, q8b_scale and q8b_accum.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    tdata: act and quant lanes, scale; tlast: row end
//   m_*      out  m_tvalid/m_tready    tdata: row dot product; tuser: saturation flag
//
// One item is taken per cycle while s_tready is high. m_tvalid rises once the
// accepted row-end transaction has passed through five register stages:
// lane multiply, block merge, scale multiply, shift and clip,
// accumulate. Reset clears the block and row state and empties the
// pipeline. While a finished row waits in the output register and is not
// read, the whole pipeline holds and s_tready is low.
module q8_0_block_dot_product_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // act_0 [23:0], act_1 [47:24], act_2 [71:48], act_3 [95:72],
  // quant_0 [103:96], quant_1 [111:104], quant_2 [119:112], quant_3 [127:120],
  // scale_bits [143:128]
  input  logic [143:0]  s_tdata,
  input  logic          s_tlast,
  output logic          m_tvalid,
  input  logic          m_tready,
  // row_value [63:0]
  output logic [63:0]   m_tdata,
  // saturated [0]
  output logic [0:0]    m_tuser
);

  logic                                adv;
  logic                                s0_valid;
  logic                                s0_last;
  logic [q8b_pkg::SCALE_W-1:0]         s0_scale;
  logic signed [q8b_pkg::PROD_W-1:0]   prod [q8b_pkg::LANES];
  q8b_pkg::close_t                     close_w;
  q8b_pkg::term_t                      term_w;
  logic                                out_sat;

  // The pipeline advances whenever the output register can take a result.
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Multiply lanes.
  for (genvar g = 0; g < q8b_pkg::LANES; g++) begin : g_lane
    q8b_lane u_lane (
      .clk   (clk),
      .en    (adv),
      .act   ($signed(s_tdata[g*q8b_pkg::ACT_W +: q8b_pkg::ACT_W])),
      .quant ($signed(s_tdata[q8b_pkg::LANES*q8b_pkg::ACT_W + g*q8b_pkg::QUANT_W
                              +: q8b_pkg::QUANT_W])),
      .prod  (prod[g])
    );
  end

  // Control that travels alongside the lane products.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_last  <= s_tlast;
      s0_scale <= s_tdata[143:128];
    end
  end

  q8b_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s0_valid),
    .in_last   (s0_last),
    .in_scale  (s0_scale),
    .prod      (prod),
    .close_out (close_w)
  );

  q8b_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .close_in (close_w),
    .term_out (term_w)
  );

  q8b_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .term_in   (term_w),
    .out_valid (m_tvalid),
    .out_value (m_tdata),
    .out_sat   (out_sat)
  );

  assign m_tuser = out_sat;

endmodule
